### rtl/itt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package itt_pkg;

    localparam int unsigned MAX_SECTIONS  = 256;
    localparam int unsigned MAX_VARIABLES = 256;
    localparam int unsigned MAX_TEXT_LEN  = 256;

    localparam int unsigned LIMIT_W     = 9;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;
    localparam int unsigned ADDR_W      = 5;
    localparam int unsigned Q_DEPTH     = 8;
    localparam int unsigned MAX_EVENTS  = 3;
    localparam int unsigned EVCNT_W     = 2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef enum logic [1:0] {
        M_IDLE,
        M_SECTION,
        M_VARIABLE,
        M_COMMENT
    } t_mode;

    typedef enum logic [2:0] {
        K_SECCHAR,
        K_SECEND,
        K_NAMECHAR,
        K_NAMEEND,
        K_VALCHAR,
        K_VALEND,
        K_TEXTEND,
        K_ERROR
    } t_kind;

    typedef enum logic [2:0] {
        REG_SECTION_LIMIT,
        REG_SECTION_NAME_LIMIT,
        REG_VARIABLE_LIMIT,
        REG_VARIABLE_NAME_LIMIT,
        REG_VARIABLE_VALUE_LIMIT
    } t_reg_idx;

    typedef struct packed {
        logic [LIMIT_W-1:0] section_limit;
        logic [LIMIT_W-1:0] section_name_limit;
        logic [LIMIT_W-1:0] variable_limit;
        logic [LIMIT_W-1:0] variable_name_limit;
        logic [LIMIT_W-1:0] variable_value_limit;
    } t_limits;

    typedef struct packed {
        t_kind       kind;
        logic [8:0]  section_index;
        logic [7:0]  variable_index;
        logic [7:0]  position;
        logic [7:0]  char_out;
        logic        last;
    } t_evt;

    typedef struct packed {
        logic [EVCNT_W-1:0]          cnt;
        t_evt [MAX_EVENTS-1:0]       ev;
    } t_step;

endpackage

`default_nettype wire

### rtl/itt_core.sv
`timescale 1ns / 1ps
`default_nettype none

module itt_core
    import itt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_fire,
    input  wire logic [7:0] i_char,
    input  wire t_limits i_limits,
    output t_step        o_step
);

    t_mode      r_mode, n_mode;
    logic       r_value_side, n_value_side;
    logic [8:0] r_section_count, n_section_count;
    logic [8:0] r_variable_count, n_variable_count;
    logic [7:0] r_char_position, n_char_position;
    logic       r_discard, n_discard;

    logic [8:0] w_sec_cap, w_sec_name_cap, w_var_cap, w_name_cap, w_val_cap, w_var_lim;
    logic [8:0] w_sec_idx, w_pos_next;
    logic [7:0] w_cur_var, w_new_var;
    logic       w_is_comment, w_starts_var, w_line_end;
    logic       w_sec_full, w_var_reject, w_fits_sec, w_fits_var, w_fits_first;

    logic [EVCNT_W-1:0]    w_cnt;
    t_evt [MAX_EVENTS-1:0] w_ev;

    function automatic logic [8:0] cap_limit(input logic [8:0] lim, input int unsigned max_v);
        if (32'(lim) < max_v) begin
            return lim;
        end
        return max_v[8:0];
    endfunction

    function automatic t_evt mk_evt(input t_kind kind, input logic [8:0] sec,
                                    input logic [7:0] var_i, input logic [7:0] pos,
                                    input logic [7:0] ch);
        t_evt e;
        e.kind           = kind;
        e.section_index  = sec;
        e.variable_index = var_i;
        e.position       = pos;
        e.char_out       = ch;
        e.last           = 1'b0;
        return e;
    endfunction

    assign w_sec_cap      = cap_limit(i_limits.section_limit, MAX_SECTIONS);
    assign w_sec_name_cap = cap_limit(i_limits.section_name_limit, MAX_TEXT_LEN);
    assign w_var_cap      = cap_limit(i_limits.variable_limit, MAX_VARIABLES);
    assign w_name_cap     = cap_limit(i_limits.variable_name_limit, MAX_TEXT_LEN);
    assign w_val_cap      = cap_limit(i_limits.variable_value_limit, MAX_TEXT_LEN);
    assign w_var_lim      = r_value_side ? w_val_cap : w_name_cap;

    assign w_sec_idx  = (r_section_count == '0) ? '0 : r_section_count - 9'd1;
    assign w_cur_var  = (r_variable_count == '0) ? '0 : 8'(r_variable_count - 9'd1);
    assign w_new_var  = r_variable_count[7:0];
    assign w_pos_next = {1'b0, r_char_position} + 9'd1;

    assign w_is_comment = (i_char == CH_SEMI) || (i_char == CH_HASH);
    assign w_starts_var = ((i_char >= 8'h61) && (i_char <= 8'h7A)) ||
                          ((i_char >= 8'h41) && (i_char <= 8'h5A)) ||
                          (i_char == CH_UNDER) || (i_char == CH_DOT) || (i_char == CH_DOLLAR);
    assign w_line_end   = (i_char == CH_NL) || (i_char == CH_NUL) || w_is_comment;

    assign w_sec_full   = r_section_count >= w_sec_cap;
    assign w_var_reject = (r_section_count == '0) || (r_variable_count >= w_var_cap);
    assign w_fits_sec   = w_pos_next < w_sec_name_cap;
    assign w_fits_var   = w_pos_next < w_var_lim;
    assign w_fits_first = 9'd1 < w_name_cap;

    always_comb begin
        n_mode           = r_mode;
        n_value_side     = r_value_side;
        n_section_count  = r_section_count;
        n_variable_count = r_variable_count;
        n_char_position  = r_char_position;
        n_discard        = r_discard;
        case (r_mode)
            M_IDLE: begin
                if (i_char == CH_LBRACK) begin
                    n_mode          = M_SECTION;
                    n_char_position = '0;
                    if (w_sec_full) begin
                        n_discard = 1'b1;
                    end else begin
                        n_discard        = 1'b0;
                        n_section_count  = r_section_count + 9'd1;
                        n_variable_count = '0;
                    end
                end else if (w_starts_var) begin
                    n_mode          = M_VARIABLE;
                    n_value_side    = 1'b0;
                    n_char_position = '0;
                    if (w_var_reject) begin
                        n_discard = 1'b1;
                    end else begin
                        n_discard        = 1'b0;
                        n_variable_count = r_variable_count + 9'd1;
                        if (w_fits_first) begin
                            n_char_position = 8'd1;
                        end
                    end
                end else if (w_is_comment) begin
                    n_mode = M_COMMENT;
                end else if (i_char == CH_NUL) begin
                    n_section_count  = '0;
                    n_variable_count = '0;
                end
            end
            M_SECTION: begin
                if ((i_char == CH_RBRACK) || (i_char == CH_NUL)) begin
                    n_char_position = '0;
                    n_discard       = 1'b0;
                    n_mode          = M_IDLE;
                    if (i_char == CH_NUL) begin
                        n_value_side     = 1'b0;
                        n_section_count  = '0;
                        n_variable_count = '0;
                    end
                end else if (!r_discard && w_fits_sec) begin
                    n_char_position = w_pos_next[7:0];
                end
            end
            M_VARIABLE: begin
                if (w_line_end) begin
                    n_value_side    = 1'b0;
                    n_char_position = '0;
                    n_discard       = 1'b0;
                    n_mode          = w_is_comment ? M_COMMENT : M_IDLE;
                    if (i_char == CH_NUL) begin
                        n_section_count  = '0;
                        n_variable_count = '0;
                    end
                end else if ((i_char == CH_EQUAL) && !r_value_side) begin
                    n_value_side    = 1'b1;
                    n_char_position = '0;
                end else if (!r_discard && w_fits_var) begin
                    n_char_position = w_pos_next[7:0];
                end
            end
            default: begin
                if (i_char == CH_NL) begin
                    n_mode = M_IDLE;
                end else if (i_char == CH_NUL) begin
                    n_mode           = M_IDLE;
                    n_value_side     = 1'b0;
                    n_section_count  = '0;
                    n_variable_count = '0;
                    n_char_position  = '0;
                    n_discard        = 1'b0;
                end
            end
        endcase
    end

    always_comb begin
        w_cnt = '0;
        w_ev  = '0;
        case (r_mode)
            M_IDLE: begin
                if (i_char == CH_LBRACK) begin
                    if (w_sec_full) begin
                        w_ev[w_cnt] = mk_evt(K_ERROR, w_sec_idx, w_cur_var, '0, i_char);
                        w_cnt       = w_cnt + 2'd1;
                    end
                end else if (w_starts_var) begin
                    if (w_var_reject) begin
                        w_ev[w_cnt] = mk_evt(K_ERROR, w_sec_idx, w_cur_var, '0, i_char);
                    end else if (w_fits_first) begin
                        w_ev[w_cnt] = mk_evt(K_NAMECHAR, w_sec_idx, w_new_var, '0, i_char);
                    end else begin
                        w_ev[w_cnt] = mk_evt(K_ERROR, w_sec_idx, w_new_var, '0, i_char);
                    end
                    w_cnt = w_cnt + 2'd1;
                end else if (!w_is_comment && (i_char == CH_NUL)) begin
                    w_ev[w_cnt] = mk_evt(K_TEXTEND, r_section_count, '0, '0, '0);
                    w_cnt       = w_cnt + 2'd1;
                end
            end
            M_SECTION: begin
                if ((i_char == CH_RBRACK) || (i_char == CH_NUL)) begin
                    if (!r_discard) begin
                        w_ev[w_cnt] = mk_evt(K_SECEND, w_sec_idx, w_cur_var,
                                             r_char_position, '0);
                        w_cnt       = w_cnt + 2'd1;
                    end
                    if (i_char == CH_NUL) begin
                        w_ev[w_cnt] = mk_evt(K_TEXTEND, r_section_count, '0, '0, '0);
                        w_cnt       = w_cnt + 2'd1;
                    end
                end else if (!r_discard) begin
                    if (w_fits_sec) begin
                        w_ev[w_cnt] = mk_evt(K_SECCHAR, w_sec_idx, w_cur_var,
                                             r_char_position, i_char);
                    end else begin
                        w_ev[w_cnt] = mk_evt(K_ERROR, w_sec_idx, w_cur_var,
                                             r_char_position, i_char);
                    end
                    w_cnt = w_cnt + 2'd1;
                end
            end
            M_VARIABLE: begin
                if (w_line_end) begin
                    if (!r_discard) begin
                        if (!r_value_side) begin
                            w_ev[w_cnt] = mk_evt(K_NAMEEND, w_sec_idx, w_cur_var,
                                                 r_char_position, '0);
                            w_cnt       = w_cnt + 2'd1;
                            w_ev[w_cnt] = mk_evt(K_VALEND, w_sec_idx, w_cur_var, '0, '0);
                        end else begin
                            w_ev[w_cnt] = mk_evt(K_VALEND, w_sec_idx, w_cur_var,
                                                 r_char_position, '0);
                        end
                        w_cnt = w_cnt + 2'd1;
                    end
                    if (i_char == CH_NUL) begin
                        w_ev[w_cnt] = mk_evt(K_TEXTEND, r_section_count, '0, '0, '0);
                        w_cnt       = w_cnt + 2'd1;
                    end
                end else if ((i_char == CH_EQUAL) && !r_value_side) begin
                    if (!r_discard) begin
                        w_ev[w_cnt] = mk_evt(K_NAMEEND, w_sec_idx, w_cur_var,
                                             r_char_position, '0);
                        w_cnt       = w_cnt + 2'd1;
                    end
                end else if (!r_discard) begin
                    if (w_fits_var) begin
                        w_ev[w_cnt] = mk_evt(r_value_side ? K_VALCHAR : K_NAMECHAR, w_sec_idx,
                                             w_cur_var, r_char_position, i_char);
                    end else begin
                        w_ev[w_cnt] = mk_evt(K_ERROR, w_sec_idx, w_cur_var,
                                             r_char_position, i_char);
                    end
                    w_cnt = w_cnt + 2'd1;
                end
            end
            default: begin
                if ((i_char != CH_NL) && (i_char == CH_NUL)) begin
                    w_ev[w_cnt] = mk_evt(K_TEXTEND, r_section_count, '0, '0, '0);
                    w_cnt       = w_cnt + 2'd1;
                end
            end
        endcase
        if (w_cnt != '0) begin
            w_ev[w_cnt - 2'd1].last = 1'b1;
        end
    end

    assign o_step = {w_cnt, w_ev};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= M_IDLE;
            r_value_side     <= 1'b0;
            r_section_count  <= '0;
            r_variable_count <= '0;
            r_char_position  <= '0;
            r_discard        <= 1'b0;
        end else if (i_fire) begin
            r_mode           <= n_mode;
            r_value_side     <= n_value_side;
            r_section_count  <= n_section_count;
            r_variable_count <= n_variable_count;
            r_char_position  <= n_char_position;
            r_discard        <= n_discard;
        end
    end

endmodule

`default_nettype wire

### rtl/itt_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module itt_fifo
    import itt_pkg::*;
#(
    parameter int unsigned DEPTH = Q_DEPTH
)(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_step i_step,
    input  wire logic  i_stall,
    output logic       o_no_room,
    output logic       o_valid,
    output t_evt       o_evt
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_evt                r_q [DEPTH];
    logic [PTR_W-1:0]    r_rd, r_wr, n_rd, n_wr;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [EVCNT_W-1:0]  w_push_n;
    logic                w_pop;

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                  input logic [EVCNT_W-1:0] k);
        logic [PTR_W:0] s;
        s = {1'b0, p} + (PTR_W+1)'(k);
        if (s >= (PTR_W+1)'(DEPTH)) begin
            s = s - (PTR_W+1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    assign w_push_n  = i_push ? i_step.cnt : '0;
    assign o_valid   = (r_count != '0);
    assign w_pop     = o_valid && !i_stall;
    assign o_no_room = (r_count > CNT_W'(DEPTH - MAX_EVENTS));
    assign o_evt     = r_q[r_rd];

    assign n_wr    = wrap_add(r_wr, w_push_n);
    assign n_rd    = w_pop ? wrap_add(r_rd, EVCNT_W'(1)) : r_rd;
    assign n_count = r_count + CNT_W'(w_push_n) - CNT_W'(w_pop);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_EVENTS; k++) begin
            if (k < int'(w_push_n)) begin
                r_q[wrap_add(r_wr, EVCNT_W'(k))] <= i_step.ev[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

### rtl/ini_text_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none
// INI text tokenizer. Text bytes enter on the input channel (i_valid, o_stall,
// i_char_in), one item per byte, and a zero byte ends the text. Each byte gives
// zero to three result items on the output channel (o_valid, i_stall and the
// o_* fields), with o_last marking the final result of a byte.
// A byte is decoded in the cycle it is accepted, and its results are written
// into a result queue of QUEUE_DEPTH entries at that edge and presented in
// order from its head. One byte can be accepted every cycle while o_stall is
// low. The output port delivers one result per cycle while i_stall is low,
// so bytes that give two or three results each are paced by the queue drain.
// o_stall rises when the queue has fewer free entries than the three results
// one byte may give. While i_stall is high the head result holds and the
// queue fills until o_stall rises; nothing is lost.
// The user writes the five limit registers over the APB port only while the
// block is idle; the block does not enforce it. Synchronous reset clears the
// parser state and queue, sets all limits to 256 and takes bytes right after.
module ini_text_tokenizer
    import itt_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = Q_DEPTH
)(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [7:0]        i_char_in,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [2:0]             o_kind,
    output logic [8:0]             o_section_index,
    output logic [7:0]             o_variable_index,
    output logic [7:0]             o_position,
    output logic [7:0]             o_char_out,
    output logic                   o_last
);

    t_limits  r_limits;
    t_reg_idx w_reg_idx;
    logic     w_fire;
    t_step    w_step;
    t_evt     w_evt;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_fire    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.section_limit        <= LIMIT_RESET;
            r_limits.section_name_limit   <= LIMIT_RESET;
            r_limits.variable_limit       <= LIMIT_RESET;
            r_limits.variable_name_limit  <= LIMIT_RESET;
            r_limits.variable_value_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (w_reg_idx)
                REG_SECTION_LIMIT:        r_limits.section_limit <= pwdata[LIMIT_W-1:0];
                REG_SECTION_NAME_LIMIT:   r_limits.section_name_limit <= pwdata[LIMIT_W-1:0];
                REG_VARIABLE_LIMIT:       r_limits.variable_limit <= pwdata[LIMIT_W-1:0];
                REG_VARIABLE_NAME_LIMIT:  r_limits.variable_name_limit <= pwdata[LIMIT_W-1:0];
                REG_VARIABLE_VALUE_LIMIT: r_limits.variable_value_limit <= pwdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_SECTION_LIMIT:        prdata = 32'(r_limits.section_limit);
            REG_SECTION_NAME_LIMIT:   prdata = 32'(r_limits.section_name_limit);
            REG_VARIABLE_LIMIT:       prdata = 32'(r_limits.variable_limit);
            REG_VARIABLE_NAME_LIMIT:  prdata = 32'(r_limits.variable_name_limit);
            REG_VARIABLE_VALUE_LIMIT: prdata = 32'(r_limits.variable_value_limit);
            default:                  prdata = '0;
        endcase
    end

    itt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_char   (i_char_in),
        .i_limits (r_limits),
        .o_step   (w_step)
    );

    itt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_fire),
        .i_step    (w_step),
        .i_stall   (i_stall),
        .o_no_room (o_stall),
        .o_valid   (o_valid),
        .o_evt     (w_evt)
    );

    assign o_kind           = w_evt.kind;
    assign o_section_index  = w_evt.section_index;
    assign o_variable_index = w_evt.variable_index;
    assign o_position       = w_evt.position;
    assign o_char_out       = w_evt.char_out;
    assign o_last           = w_evt.last;

`ifndef SYNTHESIS
    a_textend_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == K_TEXTEND) |->
        (o_last && o_variable_index == '0 && o_position == '0 && o_char_out == '0))
        else $error("text end result malformed");

    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == K_SECEND || o_kind == K_NAMEEND || o_kind == K_VALEND))
        |-> (o_char_out == '0))
        else $error("terminator carries a character");

    a_nul_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_char_in == CH_NUL) |-> (w_step.cnt != '0))
        else $error("zero byte gave no result");
`endif

endmodule

`default_nettype wire

### bench/ini_text_tokenizer_tb.sv
`timescale 1ns / 1ps

module ini_text_tokenizer_tb;
    import itt_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;

    class token_checker;
        logic [8:0]  sec_lim;
        logic [8:0]  sec_name_lim;
        logic [8:0]  var_lim;
        logic [8:0]  var_name_lim;
        logic [8:0]  var_value_lim;
        t_mode       mode;
        logic        value_side;
        logic        discard;
        logic [8:0]  sec_cnt;
        logic [8:0]  var_cnt;
        logic [8:0]  pos;
        t_evt        step_events[$];
        t_evt        expected_events[$];
        int unsigned mismatches;
        int unsigned checked;

        function new();
            sec_lim       = LIMIT_RESET;
            sec_name_lim  = LIMIT_RESET;
            var_lim       = LIMIT_RESET;
            var_name_lim  = LIMIT_RESET;
            var_value_lim = LIMIT_RESET;
            mismatches    = 0;
            checked       = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode       = M_IDLE;
            value_side = 1'b0;
            discard    = 1'b0;
            sec_cnt    = '0;
            var_cnt    = '0;
            pos        = '0;
        endfunction

        function void set_limit(t_reg_idx idx, logic [8:0] v);
            case (idx)
                REG_SECTION_LIMIT:        sec_lim = v;
                REG_SECTION_NAME_LIMIT:   sec_name_lim = v;
                REG_VARIABLE_LIMIT:       var_lim = v;
                REG_VARIABLE_NAME_LIMIT:  var_name_lim = v;
                REG_VARIABLE_VALUE_LIMIT: var_value_lim = v;
                default: ;
            endcase
        endfunction

        function int unsigned capped(logic [8:0] lim, int unsigned top);
            return (lim < top) ? int'(lim) : top;
        endfunction

        function bit is_comment(logic [7:0] c);
            return c == CH_SEMI || c == CH_HASH;
        endfunction

        function bit opens_variable(logic [7:0] c);
            return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                   c == CH_UNDER || c == CH_DOT || c == CH_DOLLAR;
        endfunction

        function void emit(t_kind kind, logic [8:0] sec, logic [7:0] vidx,
                           logic [7:0] p, logic [7:0] ch);
            t_evt e;
            e.kind           = kind;
            e.section_index  = sec;
            e.variable_index = vidx;
            e.position       = p;
            e.char_out       = ch;
            e.last           = 1'b0;
            step_events.push_back(e);
        endfunction

        function void emit_here(t_kind kind, logic [7:0] ch);
            logic [8:0] sec;
            logic [8:0] vidx;
            sec  = (sec_cnt != 0) ? sec_cnt - 9'd1 : 9'd0;
            vidx = (var_cnt != 0) ? var_cnt - 9'd1 : 9'd0;
            emit(kind, sec, vidx[7:0], pos[7:0], ch);
        endfunction

        function void end_text();
            emit(K_TEXTEND, sec_cnt, 8'd0, 8'd0, 8'd0);
            clear_state();
        endfunction

        function void entry_char(logic [7:0] c);
            int unsigned room;
            room = capped(value_side ? var_value_lim : var_name_lim, MAX_TEXT_LEN);
            if (discard) return;
            if (pos + 32'd1 < room) begin
                emit_here(value_side ? K_VALCHAR : K_NAMECHAR, c);
                pos = pos + 9'd1;
            end else begin
                emit_here(K_ERROR, c);
            end
        endfunction

        function void close_entry();
            if (!discard) begin
                if (!value_side) begin
                    emit_here(K_NAMEEND, 8'd0);
                    pos = '0;
                end
                emit_here(K_VALEND, 8'd0);
            end
            value_side = 1'b0;
            pos        = '0;
            discard    = 1'b0;
        endfunction

        function void note_char(logic [7:0] c);
            step_events.delete();
            case (mode)
                M_IDLE: begin
                    if (c == CH_LBRACK) begin
                        mode = M_SECTION;
                        pos  = '0;
                        if (sec_cnt >= capped(sec_lim, MAX_SECTIONS)) begin
                            discard = 1'b1;
                            emit_here(K_ERROR, c);
                        end else begin
                            discard = 1'b0;
                            sec_cnt = sec_cnt + 9'd1;
                            var_cnt = '0;
                        end
                    end else if (opens_variable(c)) begin
                        mode       = M_VARIABLE;
                        value_side = 1'b0;
                        pos        = '0;
                        discard    = 1'b0;
                        if (sec_cnt == 0 || var_cnt >= capped(var_lim, MAX_VARIABLES)) begin
                            discard = 1'b1;
                            emit_here(K_ERROR, c);
                        end else begin
                            var_cnt = var_cnt + 9'd1;
                        end
                        entry_char(c);
                    end else if (is_comment(c)) begin
                        mode = M_COMMENT;
                    end else if (c == CH_NUL) begin
                        end_text();
                    end
                end
                M_SECTION: begin
                    if (c == CH_RBRACK || c == CH_NUL) begin
                        if (!discard) emit_here(K_SECEND, 8'd0);
                        pos     = '0;
                        discard = 1'b0;
                        mode    = M_IDLE;
                        if (c == CH_NUL) end_text();
                    end else if (!discard) begin
                        if (pos + 32'd1 < capped(sec_name_lim, MAX_TEXT_LEN)) begin
                            emit_here(K_SECCHAR, c);
                            pos = pos + 9'd1;
                        end else begin
                            emit_here(K_ERROR, c);
                        end
                    end
                end
                M_VARIABLE: begin
                    if (c == CH_NL || c == CH_NUL || is_comment(c)) begin
                        close_entry();
                        mode = is_comment(c) ? M_COMMENT : M_IDLE;
                        if (c == CH_NUL) end_text();
                    end else if (c == CH_EQUAL && !value_side) begin
                        if (!discard) emit_here(K_NAMEEND, 8'd0);
                        value_side = 1'b1;
                        pos        = '0;
                    end else begin
                        entry_char(c);
                    end
                end
                default: begin
                    if (c == CH_NL) mode = M_IDLE;
                    else if (c == CH_NUL) end_text();
                end
            endcase
            if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
            foreach (step_events[k]) expected_events.push_back(step_events[k]);
        endfunction

        function void check_event(t_evt got);
            t_evt want;
            checked++;
            if (expected_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("unexpected result: kind=%0d sec=%0d var=%0d",
                           got.kind, got.section_index, got.variable_index);
                    $display(" pos=%0d ch=%02h last=%0b",
                             got.position, got.char_out, got.last);
                end
                return;
            end
            want = expected_events.pop_front();
            if (got.kind !== want.kind || got.section_index !== want.section_index ||
                got.variable_index !== want.variable_index ||
                got.position !== want.position || got.char_out !== want.char_out ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("result %0d: expected kind=%0d sec=%0d var=%0d",
                           checked, want.kind, want.section_index, want.variable_index);
                    $display(" pos=%0d ch=%02h last=%0b",
                             want.position, want.char_out, want.last);
                    $write("          got      kind=%0d sec=%0d var=%0d",
                           got.kind, got.section_index, got.variable_index);
                    $display(" pos=%0d ch=%02h last=%0b",
                             got.position, got.char_out, got.last);
                end
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_valid;
    logic              o_stall;
    logic [7:0]        i_char_in;
    logic              o_valid;
    logic              i_stall;
    logic [2:0]        o_kind;
    logic [8:0]        o_section_index;
    logic [7:0]        o_variable_index;
    logic [7:0]        o_position;
    logic [7:0]        o_char_out;
    logic              o_last;

    token_checker sb;
    logic [7:0]   text_q[$];
    bit           idle_en = 1'b1;
    int unsigned  text_bytes = 0;
    int unsigned  settings = 1;
    int unsigned  stall_left = 0;
    int unsigned  quiet_cycles = 0;
    t_evt         seen_evt;

    ini_text_tokenizer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_char_in        (i_char_in),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_section_index  (o_section_index),
        .o_variable_index (o_variable_index),
        .o_position       (o_position),
        .o_char_out       (o_char_out),
        .o_last           (o_last)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (!idle_en) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_evt.kind           = t_kind'(o_kind);
            seen_evt.section_index  = o_section_index;
            seen_evt.variable_index = o_variable_index;
            seen_evt.position       = o_position;
            seen_evt.char_out       = o_char_out;
            seen_evt.last           = o_last;
            sb.check_event(seen_evt);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Watchdog: no item moved for %0d cycles.", QUIET_LIMIT);
                $display("[ini_text_tokenizer] ERROR");
                $finish;
            end
        end
    end

    task automatic write_limit(t_reg_idx idx, logic [8:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'(32'(idx) * 4);
        pwdata  <= 32'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_limit(idx, v);
    endtask

    task automatic apply_limits(logic [8:0] sec, logic [8:0] sec_name, logic [8:0] vars,
                                logic [8:0] var_name, logic [8:0] var_value);
        write_limit(REG_SECTION_LIMIT, sec);
        write_limit(REG_SECTION_NAME_LIMIT, sec_name);
        write_limit(REG_VARIABLE_LIMIT, vars);
        write_limit(REG_VARIABLE_NAME_LIMIT, var_name);
        write_limit(REG_VARIABLE_VALUE_LIMIT, var_value);
        settings++;
    endtask

    task automatic send_char(logic [7:0] c);
        int unsigned gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_char_in <= c;
        do @(posedge i_clk); while (o_stall);
        sb.note_char(c);
        text_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_text();
        foreach (text_q[k]) send_char(text_q[k]);
        text_q.delete();
    endtask

    // The sender stays quiet until every predicted result has been taken.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.expected_events.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic push_str(string s);
        foreach (s[k]) text_q.push_back(s[k]);
    endtask

    function automatic logic [7:0] name_char(bit first);
        int unsigned r;
        r = $urandom_range(0, 11);
        if (r < 5) return 8'($urandom_range(8'h61, 8'h7A));
        if (r < 8) return 8'($urandom_range(8'h41, 8'h5A));
        if (r == 8) return CH_UNDER;
        if (r == 9) return CH_DOT;
        if (r == 10 || first) return CH_DOLLAR;
        return 8'($urandom_range(8'h30, 8'h39));
    endfunction

    function automatic logic [7:0] section_char();
        logic [7:0] c;
        do begin
            c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                            : 8'($urandom_range(32, 126));
        end while (c == CH_RBRACK);
        return c;
    endfunction

    function automatic logic [7:0] value_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CH_NL || c == CH_SEMI || c == CH_HASH);
        return c;
    endfunction

    function automatic logic [7:0] comment_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CH_NL);
        return c;
    endfunction

    // Mostly well-formed lines with random content; a few broken sections and noise lines.
    task automatic build_text(int unsigned max_len);
        int unsigned nlines;
        int unsigned n;
        int unsigned r;
        nlines = $urandom_range(1, 6);
        for (int l = 0; l < nlines; l++) begin
            r = (l == 0 && $urandom_range(0, 4) != 0) ? 0 : $urandom_range(0, 11);
            if (r < 3) begin
                text_q.push_back(CH_LBRACK);
                n = $urandom_range(0, max_len);
                repeat (n) text_q.push_back(section_char());
                if ($urandom_range(0, 9) != 0) text_q.push_back(CH_RBRACK);
            end else if (r < 8) begin
                text_q.push_back(name_char(1'b1));
                n = $urandom_range(0, max_len);
                repeat (n) text_q.push_back(name_char(1'b0));
                if ($urandom_range(0, 4) != 0) begin
                    text_q.push_back(CH_EQUAL);
                    n = $urandom_range(0, max_len);
                    repeat (n) text_q.push_back(value_char());
                end
                if ($urandom_range(0, 3) == 0) begin
                    text_q.push_back($urandom_range(0, 1) ? CH_SEMI : CH_HASH);
                    n = $urandom_range(0, 4);
                    repeat (n) text_q.push_back(comment_char());
                end
            end else if (r < 10) begin
                text_q.push_back($urandom_range(0, 1) ? CH_SEMI : CH_HASH);
                n = $urandom_range(0, max_len);
                repeat (n) text_q.push_back(comment_char());
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) text_q.push_back(8'($urandom_range(1, 255)));
            end
            if (l != nlines - 1 || $urandom_range(0, 2) != 0) text_q.push_back(CH_NL);
        end
        text_q.push_back(CH_NUL);
    endtask

    task automatic random_texts(int unsigned max_len, int unsigned quota);
        int unsigned sent;
        sent = 0;
        while (sent < quota) begin
            build_text(max_len);
            sent += text_q.size();
            send_text();
        end
        wait_drained();
    endtask

    initial begin
        sb        = new();
        i_rst_n   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        i_valid   = 1'b0;
        i_char_in = '0;
        i_stall   = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Variable before any section, comments, a second '=' and a comment after a value,
        // ignored line starts, a name closed by a comment, and a zero inside a section name.
        push_str("x\n;#\n[A]v=");
        text_q.push_back(8'hFF);
        push_str("=;\n ]n#\n[");
        text_q.push_back(CH_NUL);
        send_text();
        wait_drained();

        apply_limits(9'd2, 9'd4, 9'd3, 9'd4, 9'd5);
        random_texts(6, 30);
        apply_limits(9'd1, 9'd1, 9'd1, 9'd1, 9'd1);
        random_texts(3, 30);
        apply_limits(9'd0, 9'd511, 9'd511, 9'd511, 9'd511);
        random_texts(4, 30);

        apply_limits(9'd256, 9'd256, 9'd256, 9'd256, 9'd256);
        random_texts(10, 30);

        apply_limits(9'($urandom_range(1, 8)), 9'($urandom_range(1, 8)),
                     9'($urandom_range(1, 8)), 9'($urandom_range(1, 8)),
                     9'($urandom_range(1, 8)));
        random_texts(8, 30);

        idle_en = 1'b0;
        apply_limits(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)),
                     9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)),
                     9'($urandom_range(1, 256)));
        random_texts(12, 30);

        $display("Summary: %0d text bytes under %0d limit settings, %0d results checked.",
                 text_bytes, settings, sb.checked);
        $display("Limits 0 to 511 were tried, every limit overflowed, texts ended in every mode.");
        if (sb.mismatches != 0) $display("%0d results were wrong or unexpected.", sb.mismatches);
        if (sb.expected_events.size() != 0) begin
            $display("%0d expected results never arrived.", sb.expected_events.size());
        end
        if (sb.mismatches == 0 && sb.expected_events.size() == 0) begin
            $display("[ini_text_tokenizer] OK");
        end else begin
            $display("[ini_text_tokenizer] ERROR");
        end
        $finish;
    end

endmodule
